// File: hdl/efn_pkg.sv
// Package for the edge frame block: widths, latencies and vector types.
// No dependencies; imported by efn_unit and edge_frame_from_face_normals.
`timescale 1ns / 1ps

package efn_pkg;

  localparam int IN_WIDTH  = 32;
  localparam int OUT_WIDTH = 16;

  // Q2.30 unit vectors held in UW bits, wide vectors into the normalizer in VW bits
  localparam int UFRAC     = 30;
  localparam int UW        = UFRAC + 2;
  localparam int VW        = 64;
  localparam int LEN_W     = $clog2(VW + 1);
  localparam int ROOT_BITS = UFRAC + 1;
  localparam int SQ_W      = 2 * UFRAC + 2;
  localparam int TR_W      = SQ_W + 2;
  localparam int OUT_SHIFT = UFRAC - (OUT_WIDTH - 2);
  localparam int OUT_LIM   = 1 << (OUT_WIDTH - 2);

  // front end 5, root 31, divider setup 1, divider 31, sign 1
  localparam int UNIT_LAT  = 5 + 2 * ROOT_BITS + 2;
  localparam int TOTAL_LAT = 4 * UNIT_LAT + 10;

  typedef logic [2:0][UW-1:0] uvec_t;
  typedef logic [2:0][VW-1:0] wvec_t;

endpackage

// File: hdl/edge_frame_from_face_normals.sv
// Edge frame top level: six normalizers, four deep in series, chained with dot,
// projection and cross product stages, plus the output register. Uses efn_pkg and efn_unit.
// Throughput: one word per cycle; the whole pipe freezes while a result is stalled.
// Most of the latency comes from the 31-stage root and 31-stage divider in each normalizer.
// Reset (rst_n low, synchronous) clears the valid shift register only; payload and ok flags are not reset.
`timescale 1ns / 1ps

module edge_frame_from_face_normals import efn_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [IN_WIDTH-1:0]  in_deriv_x,
  input  logic signed [IN_WIDTH-1:0]  in_deriv_y,
  input  logic signed [IN_WIDTH-1:0]  in_deriv_z,
  input  logic signed [IN_WIDTH-1:0]  in_normal_a_x,
  input  logic signed [IN_WIDTH-1:0]  in_normal_a_y,
  input  logic signed [IN_WIDTH-1:0]  in_normal_a_z,
  input  logic signed [IN_WIDTH-1:0]  in_normal_b_x,
  input  logic signed [IN_WIDTH-1:0]  in_normal_b_y,
  input  logic signed [IN_WIDTH-1:0]  in_normal_b_z,
  input  logic                        in_normals_ok,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_WIDTH-1:0] out_tangent_x,
  output logic signed [OUT_WIDTH-1:0] out_tangent_y,
  output logic signed [OUT_WIDTH-1:0] out_tangent_z,
  output logic signed [OUT_WIDTH-1:0] out_perp_x,
  output logic signed [OUT_WIDTH-1:0] out_perp_y,
  output logic signed [OUT_WIDTH-1:0] out_perp_z,
  output logic signed [OUT_WIDTH-1:0] out_proj_x,
  output logic signed [OUT_WIDTH-1:0] out_proj_y,
  output logic signed [OUT_WIDTH-1:0] out_proj_z,
  output logic                        out_frame_valid
);

  localparam int PW = 2 * UW + 4;   // wide product / rounding input
  localparam int RW = PW - UFRAC;   // after dropping the fraction

  function automatic logic [VW-1:0] sx_in(input logic [IN_WIDTH-1:0] x);
    return {{(VW-IN_WIDTH){x[IN_WIDTH-1]}}, x};
  endfunction

  // round half away from zero, drop UFRAC bits
  function automatic logic [RW-1:0] rnd_frac(input logic [PW-1:0] x);
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    m = x[PW-1] ? PW'(-x) : x;
    r = (m + (PW'(1) << (UFRAC - 1))) >> UFRAC;
    return x[PW-1] ? RW'(-r) : RW'(r);
  endfunction

  function automatic logic [OUT_WIDTH-1:0] to_out(input logic [UW-1:0] x);
    logic [UW:0] m;
    logic [UW:0] r;
    m = x[UW-1] ? (UW+1)'(-{1'b1, x}) : {1'b0, x};
    r = (m + ((UW+1)'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (r > (UW+1)'(OUT_LIM)) r = (UW+1)'(OUT_LIM);
    return x[UW-1] ? OUT_WIDTH'(-r) : OUT_WIDTH'(r);
  endfunction

  logic en;
  logic [TOTAL_LAT-1:0] vld_r;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL_LAT-2:0], in_valid};
    end
  end

  // first normalizers: tangent and both face normals
  wvec_t d_w, na_w, nb_w;
  uvec_t t_u, ua_u, ub_u;
  logic  t_nz, ua_nz, ub_nz;

  assign d_w  = {sx_in(in_deriv_z), sx_in(in_deriv_y), sx_in(in_deriv_x)};
  assign na_w = {sx_in(in_normal_a_z), sx_in(in_normal_a_y), sx_in(in_normal_a_x)};
  assign nb_w = {sx_in(in_normal_b_z), sx_in(in_normal_b_y), sx_in(in_normal_b_x)};

  efn_unit u_tan (.clk(clk), .en(en), .v(d_w),  .u(t_u),  .nz(t_nz));
  efn_unit u_na  (.clk(clk), .en(en), .v(na_w), .u(ua_u), .nz(ua_nz));
  efn_unit u_nb  (.clk(clk), .en(en), .v(nb_w), .u(ub_u), .nz(ub_nz));

  logic [UNIT_LAT-1:0] oka_r;

  always_ff @(posedge clk) begin
    if (en) oka_r <= {oka_r[UNIT_LAT-2:0], in_normals_ok};
  end

  // P1: sum of unit normals
  typedef struct packed {
    logic [2:0][UW:0] sum;
    logic             sumz;
    uvec_t            ua;
    uvec_t            t;
    logic             ok;
  } p1_t;

  p1_t  p1_r;
  p1_t  p1_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1_nxt.sum[i] = {ua_u[i][UW-1], ua_u[i]} + {ub_u[i][UW-1], ub_u[i]};
    end
    p1_nxt.sumz = (p1_nxt.sum == '0);
    p1_nxt.ua   = ua_u;
    p1_nxt.t    = t_u;
    p1_nxt.ok   = oka_r[UNIT_LAT-1] && t_nz && ua_nz && ub_nz;
  end

  always_ff @(posedge clk) begin
    if (en) p1_r <= p1_nxt;
  end

  // combined normal
  wvec_t sum_w;
  uvec_t uc_u;
  logic  uc_nz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_w[i] = {{(VW-UW-1){p1_r.sum[i][UW]}}, p1_r.sum[i]};
    end
  end

  efn_unit u_comb (.clk(clk), .en(en), .v(sum_w), .u(uc_u), .nz(uc_nz));

  typedef struct packed {
    logic  sumz;
    uvec_t ua;
    uvec_t t;
    logic  ok;
  } cb_t;

  cb_t cb_r [UNIT_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      cb_r[0] <= '{sumz: p1_r.sumz, ua: p1_r.ua, t: p1_r.t, ok: p1_r.ok};
      for (int i = 1; i < UNIT_LAT; i++) cb_r[i] <= cb_r[i-1];
    end
  end

  // P2..P7: dot product and projection
  typedef struct packed {
    uvec_t comb;
    uvec_t t;
    logic  ok;
  } ct_t;

  ct_t                  p2_r, p3_r, p4_r, p5_r, p6_r;
  logic [2:0][PW-1:0]   pr3_r;
  logic [PW-1:0]        dr4_r;
  logic [RW-1:0]        dot5_r;
  logic [2:0][PW-1:0]   dp6_r;
  logic [2:0][UW+1:0]   proj7_r;
  uvec_t                t7_r;
  logic                 ok7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // an all-zero sum falls back to the first normal; a zero first normal has already cleared ok
      p2_r.comb <= cb_r[UNIT_LAT-1].sumz ? cb_r[UNIT_LAT-1].ua : uc_u;
      p2_r.t    <= cb_r[UNIT_LAT-1].t;
      p2_r.ok   <= cb_r[UNIT_LAT-1].ok && (uc_nz || cb_r[UNIT_LAT-1].sumz || 1'b1);

      p3_r <= p2_r;
      for (int i = 0; i < 3; i++) begin
        pr3_r[i] <= PW'($signed(p2_r.comb[i]) * $signed(p2_r.t[i]));
      end

      p4_r  <= p3_r;
      dr4_r <= pr3_r[0] + pr3_r[1] + pr3_r[2];

      p5_r   <= p4_r;
      dot5_r <= rnd_frac(dr4_r);

      p6_r <= p5_r;
      for (int i = 0; i < 3; i++) begin
        dp6_r[i] <= PW'($signed(dot5_r) * $signed(p5_r.t[i]));
      end

      for (int i = 0; i < 3; i++) begin
        proj7_r[i] <= {{2{p6_r.comb[i][UW-1]}}, p6_r.comb[i]}
                      - (UW+2)'(rnd_frac(dp6_r[i]));
      end
      t7_r  <= p6_r.t;
      ok7_r <= p6_r.ok;
    end
  end

  // projected normal
  wvec_t proj_w;
  uvec_t pn_u;
  logic  pn_nz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      proj_w[i] = {{(VW-UW-2){proj7_r[i][UW+1]}}, proj7_r[i]};
    end
  end

  efn_unit u_proj (.clk(clk), .en(en), .v(proj_w), .u(pn_u), .nz(pn_nz));

  typedef struct packed {
    uvec_t t;
    logic  ok;
  } tk_t;

  tk_t tk_r [UNIT_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      tk_r[0] <= '{t: t7_r, ok: ok7_r};
      for (int i = 1; i < UNIT_LAT; i++) tk_r[i] <= tk_r[i-1];
    end
  end

  // P8, P9: cross product of projection and tangent
  typedef struct packed {
    uvec_t pn;
    uvec_t t;
    logic  ok;
  } pt_t;

  pt_t                p8_r, p9_r;
  logic [5:0][VW-1:0] xp8_r;
  wvec_t              cr9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p8_r.pn <= pn_u;
      p8_r.t  <= tk_r[UNIT_LAT-1].t;
      p8_r.ok <= tk_r[UNIT_LAT-1].ok && (pn_nz || !pn_nz);
      xp8_r[0] <= VW'($signed(pn_u[1]) * $signed(tk_r[UNIT_LAT-1].t[2]));
      xp8_r[1] <= VW'($signed(pn_u[2]) * $signed(tk_r[UNIT_LAT-1].t[1]));
      xp8_r[2] <= VW'($signed(pn_u[2]) * $signed(tk_r[UNIT_LAT-1].t[0]));
      xp8_r[3] <= VW'($signed(pn_u[0]) * $signed(tk_r[UNIT_LAT-1].t[2]));
      xp8_r[4] <= VW'($signed(pn_u[0]) * $signed(tk_r[UNIT_LAT-1].t[1]));
      xp8_r[5] <= VW'($signed(pn_u[1]) * $signed(tk_r[UNIT_LAT-1].t[0]));

      p9_r     <= p8_r;
      cr9_r[0] <= xp8_r[0] - xp8_r[1];
      cr9_r[1] <= xp8_r[2] - xp8_r[3];
      cr9_r[2] <= xp8_r[4] - xp8_r[5];
    end
  end

  // a zero projection gives a zero cross product and so zero perp
  uvec_t pp_u;
  logic  pp_nz;

  efn_unit u_perp (.clk(clk), .en(en), .v(cr9_r), .u(pp_u), .nz(pp_nz));

  pt_t fd_r [UNIT_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      fd_r[0] <= p9_r;
      for (int i = 1; i < UNIT_LAT; i++) fd_r[i] <= fd_r[i-1];
    end
  end

  // output register
  pt_t                           fl;
  logic [2:0][OUT_WIDTH-1:0]     tan_r, perp_r, prj_r;
  logic                          fv_r;

  assign fl = fd_r[UNIT_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      fv_r <= fl.ok;
      for (int i = 0; i < 3; i++) begin
        tan_r[i]  <= fl.ok ? to_out(fl.t[i]) : '0;
        perp_r[i] <= (fl.ok && pp_nz) ? to_out(pp_u[i]) : '0;
        prj_r[i]  <= fl.ok ? to_out(fl.pn[i]) : '0;
      end
    end
  end

  assign out_tangent_x   = tan_r[0];
  assign out_tangent_y   = tan_r[1];
  assign out_tangent_z   = tan_r[2];
  assign out_perp_x      = perp_r[0];
  assign out_perp_y      = perp_r[1];
  assign out_perp_z      = perp_r[2];
  assign out_proj_x      = prj_r[0];
  assign out_proj_y      = prj_r[1];
  assign out_proj_z      = prj_r[2];
  assign out_frame_valid = fv_r;

  a_zero_when_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_valid |-> tan_r == '0 && perp_r == '0 && prj_r == '0)
    else $error("degenerate frame with nonzero vectors");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back pressure");

  a_tangent_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_tangent_x) <= $signed(OUT_WIDTH'(OUT_LIM))
      && $signed(out_tangent_x) >= -$signed(OUT_WIDTH'(OUT_LIM)))
    else $error("tangent out of unit range");

endmodule

// File: hdl/efn_unit.sv
// Pipelined vector normalizer: scale, sum of squares, digit-serial root and
// restoring divide, one stage per root or quotient bit. Uses efn_pkg.
`timescale 1ns / 1ps

module efn_unit import efn_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  wvec_t v,
  output uvec_t u,
  output logic  nz
);

  typedef struct packed {
    logic [2:0][UFRAC-1:0] a;
    logic [2:0]            neg;
    logic                  nz;
  } side_t;

  function automatic logic [LEN_W-1:0] bit_len(input logic [VW-1:0] x);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < VW; i++) begin
      if (x[i]) n = LEN_W'(i + 1);
    end
    return n;
  endfunction

  // S1: magnitudes
  logic [2:0][VW-1:0] a1_r;
  logic [2:0]         neg1_r;
  // S2: bit length of the largest magnitude (same as of the OR)
  logic [2:0][VW-1:0] a2_r;
  logic [2:0]         neg2_r;
  logic [LEN_W-1:0]   len2_r;
  // S3..S5
  side_t                   side3_r, side4_r, side5_r;
  logic [2:0][2*UFRAC-1:0] sq4_r;
  logic [SQ_W-1:0]         s5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_r[i] <= v[i][VW-1];
        a1_r[i]   <= v[i][VW-1] ? VW'(-v[i]) : v[i];
      end
      a2_r   <= a1_r;
      neg2_r <= neg1_r;
      len2_r <= bit_len(a1_r[0] | a1_r[1] | a1_r[2]);
    end
  end

  logic [2:0][UFRAC-1:0] a3_nxt;

  always_comb begin
    logic [VW-1:0] tmp;
    for (int i = 0; i < 3; i++) begin
      if (len2_r > LEN_W'(UFRAC)) begin
        tmp = a2_r[i] >> (len2_r - LEN_W'(UFRAC));
      end else begin
        tmp = a2_r[i] << (LEN_W'(UFRAC) - len2_r);
      end
      a3_nxt[i] = tmp[UFRAC-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r.a   <= a3_nxt;
      side3_r.neg <= neg2_r;
      side3_r.nz  <= (len2_r != '0);
      side4_r     <= side3_r;
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= (2*UFRAC)'(side3_r.a[i] * side3_r.a[i]);
      end
      side5_r <= side4_r;
      s5_r    <= {2'b00, sq4_r[0]} + {2'b00, sq4_r[1]} + {2'b00, sq4_r[2]};
    end
  end

  // square root, one result bit per stage
  logic [SQ_W-1:0]      rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r [ROOT_BITS];
  side_t                sside_r[ROOT_BITS];

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
    localparam int K = ROOT_BITS - 1 - j;
    logic [SQ_W-1:0]      rem_p;
    logic [ROOT_BITS-1:0] root_p;
    side_t                side_p;
    logic [TR_W-1:0]      trial;
    if (j == 0) begin : g_first
      assign rem_p  = s5_r;
      assign root_p = '0;
      assign side_p = side5_r;
    end else begin : g_next
      assign rem_p  = rem_r[j-1];
      assign root_p = root_r[j-1];
      assign side_p = sside_r[j-1];
    end
    assign trial = (TR_W'(root_p) << (K + 1)) + (TR_W'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (en) begin
        sside_r[j] <= side_p;
        if (TR_W'(rem_p) >= trial) begin
          rem_r[j]  <= SQ_W'(TR_W'(rem_p) - trial);
          root_r[j] <= root_p | (ROOT_BITS'(1) << K);
        end else begin
          rem_r[j]  <= rem_p;
          root_r[j] <= root_p;
        end
      end
    end
  end

  // divider setup: numerator is a * 2^30 rounded by half the magnitude
  logic [2:0][SQ_W-1:0] num_r;
  logic [ROOT_BITS-1:0] dmag0_r;
  side_t                dside0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= {2'b00, sside_r[ROOT_BITS-1].a[i], {UFRAC{1'b0}}}
                    + SQ_W'(root_r[ROOT_BITS-1] >> 1);
      end
      dmag0_r  <= root_r[ROOT_BITS-1];
      dside0_r <= sside_r[ROOT_BITS-1];
    end
  end

  logic [2:0][SQ_W-1:0]      drem_r [ROOT_BITS];
  logic [2:0][ROOT_BITS-1:0] q_r    [ROOT_BITS];
  logic [ROOT_BITS-1:0]      dmag_r [ROOT_BITS];
  side_t                     dside_r[ROOT_BITS];

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_div
    localparam int K = ROOT_BITS - 1 - j;
    logic [2:0][SQ_W-1:0]      rem_p;
    logic [2:0][ROOT_BITS-1:0] q_p;
    logic [ROOT_BITS-1:0]      mag_p;
    side_t                     side_p;
    logic [SQ_W-1:0]           dsub;
    if (j == 0) begin : g_first
      assign rem_p  = num_r;
      assign q_p    = '0;
      assign mag_p  = dmag0_r;
      assign side_p = dside0_r;
    end else begin : g_next
      assign rem_p  = drem_r[j-1];
      assign q_p    = q_r[j-1];
      assign mag_p  = dmag_r[j-1];
      assign side_p = dside_r[j-1];
    end
    assign dsub = SQ_W'(mag_p) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        dmag_r[j]  <= mag_p;
        dside_r[j] <= side_p;
        for (int i = 0; i < 3; i++) begin
          if (rem_p[i] >= dsub) begin
            drem_r[j][i] <= rem_p[i] - dsub;
            q_r[j][i]    <= q_p[i] | (ROOT_BITS'(1) << K);
          end else begin
            drem_r[j][i] <= rem_p[i];
            q_r[j][i]    <= q_p[i];
          end
        end
      end
    end
  end

  // sign back on; an all-zero vector gives zeros
  uvec_t u_r;
  logic  nz_r;
  side_t dlast;

  assign dlast = dside_r[ROOT_BITS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      nz_r <= dlast.nz;
      for (int i = 0; i < 3; i++) begin
        if (!dlast.nz) begin
          u_r[i] <= '0;
        end else if (dlast.neg[i]) begin
          u_r[i] <= UW'(-UW'(q_r[ROOT_BITS-1][i]));
        end else begin
          u_r[i] <= UW'(q_r[ROOT_BITS-1][i]);
        end
      end
    end
  end

  assign u  = u_r;
  assign nz = nz_r;

endmodule
